### src/crb_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// crb_pkg
// Shared widths, register indexes and beat types for the cubic root finder.
// ============================================================================
package crb_pkg;

    localparam int X_WIDTH      = 32;
    localparam int FRAC_BITS    = 16;
    localparam int COEF_WIDTH   = 16;
    localparam int TOL_WIDTH    = 31;
    localparam int CFG_WIDTH    = (COEF_WIDTH > TOL_WIDTH) ? COEF_WIDTH : TOL_WIDTH;
    localparam int CFG_IDX_W    = 3;

    // multiplier limb of the evaluator
    localparam int LIMB_LOG     = 5;
    localparam int LIMB_W       = 1 << LIMB_LOG;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_CUBIC  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_SQUARE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_LINEAR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_CONST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 3'd4;

    localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(7);

    typedef struct packed {
        logic signed [X_WIDTH-1:0] bracket_low;
        logic signed [X_WIDTH-1:0] bracket_high;
    } t_in_beat;

    typedef struct packed {
        logic signed [X_WIDTH-1:0] root;
        logic                      exact_hit;
    } t_out_beat;

    typedef struct packed {
        logic neg;
        logic zero;
    } t_eval_res;

endpackage

### src/crb_eval.sv
`timescale 1ns / 1ps
// ============================================================================
// crb_eval
// Exact sign of the scaled cubic by Horner steps on one shared limb multiplier.
// ============================================================================
module crb_eval
    import crb_pkg::*;
#(
    parameter int FRAC_BITS_P = FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [X_WIDTH-1:0]    i_x,
    input  logic signed [COEF_WIDTH-1:0] i_coef_a,
    input  logic signed [COEF_WIDTH-1:0] i_coef_b,
    input  logic signed [COEF_WIDTH-1:0] i_coef_c,
    input  logic signed [COEF_WIDTH-1:0] i_coef_d,
    output logic                         o_done,
    output t_eval_res                    o_res
);

    localparam int M     = (X_WIDTH - 1 > FRAC_BITS_P) ? X_WIDTH - 1 : FRAC_BITS_P;
    localparam int ACC_W = COEF_WIDTH + 3 * M + 3;
    localparam int W0    = COEF_WIDTH;
    localparam int W1    = COEF_WIDTH + M + 1;
    localparam int W2    = COEF_WIDTH + 2 * M + 2;
    localparam int N0    = (W0 + LIMB_W - 2) / LIMB_W;
    localparam int N1    = (W1 + LIMB_W - 2) / LIMB_W;
    localparam int N2    = (W2 + LIMB_W - 2) / LIMB_W;
    localparam int LCW   = (N2 > 1) ? $clog2(N2) : 1;
    localparam int SHW   = LCW + LIMB_LOG;
    localparam int PW    = X_WIDTH + LIMB_W + 1;

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_MUL  = 2'd1;
    localparam logic [1:0] P_ADD  = 2'd2;
    localparam logic [1:0] P_SIGN = 2'd3;

    localparam logic [1:0] STEP_LAST = 2'd2;

    logic [1:0]                r_phase;
    logic [1:0]                r_step;
    logic [LCW-1:0]            r_limb;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   r_sum;
    logic signed [X_WIDTH-1:0] r_x;
    logic                      r_done;
    t_eval_res                 r_res;

    logic [LCW-1:0]            top_limb;
    logic [LCW-1:0]            next_top;
    logic signed [ACC_W-1:0]   k_term;
    logic [SHW-1:0]            shamt;
    logic signed [ACC_W-1:0]   shifted;
    logic signed [LIMB_W:0]    limb_val;
    logic signed [PW-1:0]      prod;
    logic signed [ACC_W-1:0]   n_sum;

    function automatic logic [LCW-1:0] f_top(input logic [1:0] step);
        logic [LCW-1:0] t;
        unique case (step)
            2'd0:    t = LCW'(N0 - 1);
            2'd1:    t = LCW'(N1 - 1);
            default: t = LCW'(N2 - 1);
        endcase
        return t;
    endfunction

    assign top_limb = f_top(r_step);
    assign next_top = f_top(r_step + 2'd1);

    always_comb begin
        unique case (r_step)
            2'd0:    k_term = ACC_W'(i_coef_b) <<< FRAC_BITS_P;
            2'd1:    k_term = ACC_W'(i_coef_c) <<< (2 * FRAC_BITS_P);
            default: k_term = ACC_W'(i_coef_d) <<< (3 * FRAC_BITS_P);
        endcase
    end

    assign shamt   = {r_limb, LIMB_LOG'(0)};
    assign shifted = r_acc >>> shamt;

    always_comb begin
        if (r_limb == top_limb) begin
            limb_val = shifted[LIMB_W:0];
        end else begin
            limb_val = {1'b0, shifted[LIMB_W-1:0]};
        end
    end

    assign prod  = r_x * limb_val;
    assign n_sum = ((r_limb == top_limb) ? ACC_W'(0) : (r_sum <<< LIMB_W)) + ACC_W'(prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_phase == P_SIGN);
            unique case (r_phase)
                P_IDLE: begin
                    if (i_start) begin
                        r_x     <= i_x;
                        r_acc   <= ACC_W'(i_coef_a);
                        r_step  <= 2'd0;
                        r_limb  <= f_top(2'd0);
                        r_phase <= P_MUL;
                    end
                end
                P_MUL: begin
                    r_sum <= n_sum;
                    if (r_limb == '0) begin
                        r_phase <= P_ADD;
                    end else begin
                        r_limb <= r_limb - LCW'(1);
                    end
                end
                P_ADD: begin
                    r_acc <= r_sum + k_term;
                    if (r_step == STEP_LAST) begin
                        r_phase <= P_SIGN;
                    end else begin
                        r_step  <= r_step + 2'd1;
                        r_limb  <= next_top;
                        r_phase <= P_MUL;
                    end
                end
                P_SIGN: begin
                    r_res   <= {r_acc[ACC_W-1], (r_acc == '0)};
                    r_phase <= P_IDLE;
                end
                default: r_phase <= P_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

### src/cubic_root_bisection_top.sv
`timescale 1ns / 1ps
// ============================================================================
// cubic_root_bisection_top
// Bisection root finder for a cubic with Q8.8 coefficients over Q16.16 x.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one bracket per beat.
//   Output channel (o_out_valid / i_out_ready) returns one root per bracket,
//   with exact_hit set only when an evaluation found the cubic exactly zero there.
//   Config port: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0..3 coefficients cubic/square/linear/const, 4 tolerance); other
//   indexes are dropped. Write only while the block is idle.
// Timing:
//   One bracket at a time; o_in_ready is high only when idle.
//   A halving is one width/midpoint check, one polynomial
//   evaluation (6 limb multiplies, 3 adds and a sign step) on the single
//   shared multiplier, and one step to take the sign. The first halving
//   adds one more evaluation for the left end. A bracket already within
//   tolerance goes from the width check straight to the output.
// Reset: synchronous, active low; coefficients clear, tolerance goes to 7,
//   any bracket in progress is dropped.
// Stall: a finished result holds on the output until i_out_ready.
// ============================================================================
module cubic_root_bisection_top
    import crb_pkg::*;
#(
    parameter int FRAC_BITS_P = FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_beat             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_beat            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_WIDTH-1:0] i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_OUT   = 3'd3;

    localparam int DW = X_WIDTH + 1;

    logic [2:0]                   r_state;
    logic signed [COEF_WIDTH-1:0] r_coef_a;
    logic signed [COEF_WIDTH-1:0] r_coef_b;
    logic signed [COEF_WIDTH-1:0] r_coef_c;
    logic signed [COEF_WIDTH-1:0] r_coef_d;
    logic [TOL_WIDTH-1:0]         r_tol;
    logic signed [X_WIDTH-1:0]    r_lo;
    logic signed [X_WIDTH-1:0]    r_hi;
    logic signed [X_WIDTH-1:0]    r_mid;
    logic                         r_need_lo;
    t_eval_res                    r_sign_lo;
    logic                         r_out_valid;
    t_out_beat                    r_out;

    logic signed [DW-1:0]         diff;
    logic [DW-1:0]                width;
    logic signed [DW-1:0]         sum;
    logic signed [X_WIDTH-1:0]    mid;
    logic [TOL_WIDTH-1:0]         tol_eff;
    logic                         narrow;
    logic                         eval_start;
    logic signed [X_WIDTH-1:0]    eval_x;
    logic                         eval_done;
    t_eval_res                    eval_res;
    logic                         opposite;

    assign diff    = DW'(r_hi) - DW'(r_lo);
    assign width   = diff[DW-1] ? DW'(-diff) : DW'(diff);
    assign sum     = DW'(r_lo) + DW'(r_hi);
    assign mid     = sum[DW-1:1];
    assign tol_eff = (r_tol == '0) ? TOL_WIDTH'(1) : r_tol;
    assign narrow  = (width <= DW'(tol_eff));

    assign eval_start = (r_state == S_CHECK) && !narrow;
    assign eval_x     = r_need_lo ? r_lo : mid;
    assign opposite   = !eval_res.zero && !r_sign_lo.zero && (eval_res.neg != r_sign_lo.neg);

    crb_eval #(
        .FRAC_BITS_P (FRAC_BITS_P)
    ) u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (eval_start),
        .i_x      (eval_x),
        .i_coef_a (r_coef_a),
        .i_coef_b (r_coef_b),
        .i_coef_c (r_coef_c),
        .i_coef_d (r_coef_d),
        .o_done   (eval_done),
        .o_res    (eval_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a <= '0;
            r_coef_b <= '0;
            r_coef_c <= '0;
            r_coef_d <= '0;
            r_tol    <= TOL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_COEF_CUBIC:  r_coef_a <= i_cfg_data[COEF_WIDTH-1:0];
                REG_COEF_SQUARE: r_coef_b <= i_cfg_data[COEF_WIDTH-1:0];
                REG_COEF_LINEAR: r_coef_c <= i_cfg_data[COEF_WIDTH-1:0];
                REG_COEF_CONST:  r_coef_d <= i_cfg_data[COEF_WIDTH-1:0];
                REG_TOLERANCE:   r_tol    <= i_cfg_data[TOL_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_need_lo   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_lo      <= i_in_data.bracket_low;
                        r_hi      <= i_in_data.bracket_high;
                        r_need_lo <= 1'b1;
                        r_state   <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (narrow) begin
                        r_out       <= {mid, 1'b0};
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end else begin
                        r_mid   <= mid;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (eval_done) begin
                        if (r_need_lo) begin
                            r_sign_lo <= eval_res;
                            r_need_lo <= 1'b0;
                            r_state   <= S_CHECK;
                        end else if (eval_res.zero) begin
                            r_out       <= {r_mid, 1'b1};
                            r_out_valid <= 1'b1;
                            r_state     <= S_OUT;
                        end else if (opposite) begin
                            r_hi    <= r_mid;
                            r_state <= S_CHECK;
                        end else begin
                            r_lo      <= r_mid;
                            r_sign_lo <= eval_res;
                            r_state   <= S_CHECK;
                        end
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("input ready while a result is pending");

    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_CHECK))
        else $error("accepted bracket did not start a width check");

    a_done_in_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eval_done |-> (r_state == S_EVAL))
        else $error("evaluator finished outside the wait state");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eval_start |=> !eval_done)
        else $error("evaluator result came back too early");
`endif

endmodule
